### rtl/usc_pkg.sv
// Shared types, constants and calendar helpers for the seconds-to-calendar block.
`default_nettype none
package usc_pkg;

   localparam int unsigned SecWidth    = 32;
   localparam int unsigned ProdWidth   = 2 * SecWidth;
   localparam int unsigned RemWidth    = 6;
   localparam int unsigned DaysWidth   = 16;
   localparam int unsigned YearLenW    = 9;
   localparam int unsigned MonthLenW   = 5;

   // Quotient position in the reciprocal product for each divisor.
   localparam int unsigned QuoLsb60    = 37;
   localparam int unsigned QuoLsb24    = 36;
   localparam int unsigned QuoLsb7     = 19;

   localparam logic [SecWidth-1:0]  RecipBy60    = 32'h8888_8889;
   localparam logic [SecWidth-1:0]  RecipBy24    = 32'hAAAA_AAAB;
   localparam logic [SecWidth-1:0]  RecipBy7     = 32'd74899;
   localparam logic [1:0]           EpochMod4    = 2'd2;
   localparam logic [6:0]           EpochMod100  = 7'd70;
   localparam logic [8:0]           EpochMod400  = 9'd370;
   localparam logic [2:0]           EpochWdShift = 3'd4;
   localparam logic [7:0]           YearLimit    = 8'd255;
   localparam logic [3:0]           LastMonth    = 4'd11;
   localparam logic [YearLenW-1:0]  LeapYearLen  = 9'd366;
   localparam logic [YearLenW-1:0]  PlainYearLen = 9'd365;

   typedef enum logic [1:0] {
      PH_SEC,
      PH_MIN,
      PH_HOUR,
      PH_WDAY
   } phase_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_FINISH,
      ST_YEAR,
      ST_MONTH,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic      load;
      logic      div_step;
      logic      finish;
      phase_type phase;
      logic      year_step;
      logic      month_step;
      logic      emit;
   } cmd_type;

   typedef struct packed {
      logic year_fits;
      logic month_fits;
   } status_type;

   function automatic logic [RemWidth-1:0] divisor_of(input phase_type ph);
      logic [RemWidth-1:0] d;
      unique case (ph)
         PH_SEC:  d = 6'd60;
         PH_MIN:  d = 6'd60;
         PH_HOUR: d = 6'd24;
         PH_WDAY: d = 6'd7;
         default: d = 6'd60;
      endcase
      return d;
   endfunction

   function automatic logic [SecWidth-1:0] recip_of(input phase_type ph);
      logic [SecWidth-1:0] m;
      unique case (ph)
         PH_SEC:  m = RecipBy60;
         PH_MIN:  m = RecipBy60;
         PH_HOUR: m = RecipBy24;
         PH_WDAY: m = RecipBy7;
         default: m = RecipBy60;
      endcase
      return m;
   endfunction

   // Month index is zero based; February depends on the leap flag.
   function automatic logic [MonthLenW-1:0] month_len(input logic [3:0] m, input logic leap);
      logic [MonthLenW-1:0] len;
      unique case (m)
         4'd0:    len = 5'd31;
         4'd1:    len = leap ? 5'd29 : 5'd28;
         4'd2:    len = 5'd31;
         4'd3:    len = 5'd30;
         4'd4:    len = 5'd31;
         4'd5:    len = 5'd30;
         4'd6:    len = 5'd31;
         4'd7:    len = 5'd31;
         4'd8:    len = 5'd30;
         4'd9:    len = 5'd31;
         4'd10:   len = 5'd30;
         4'd11:   len = 5'd31;
         default: len = 5'd31;
      endcase
      return len;
   endfunction

endpackage
`default_nettype wire

### rtl/usc_dpath.sv
// Datapath: reciprocal-multiply constant divider, year and month walkers, result register.
`default_nettype none
module usc_dpath
   import usc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic [SecWidth-1:0]  req_seconds_since_epoch,
   input  wire cmd_type              cmd,
   output status_type                status,
   output logic [5:0]                rsp_second_of_minute,
   output logic [5:0]                rsp_minute_of_hour,
   output logic [4:0]                rsp_hour_of_day,
   output logic [2:0]                rsp_weekday,
   output logic [7:0]                rsp_year_offset,
   output logic [3:0]                rsp_month_number,
   output logic [4:0]                rsp_day_of_month
);

   logic [SecWidth-1:0]  dvd_ff, dvd_in;
   logic [SecWidth-1:0]  quo_ff, quo_in;
   logic [5:0]           sec_ff, min_ff;
   logic [4:0]           hour_ff;
   logic [2:0]           wday_ff;
   logic [DaysWidth-1:0] days_ff, days_in;
   logic [7:0]           year_ff, year_in;
   logic [1:0]           mod4_ff, mod4_in;
   logic [6:0]           mod100_ff, mod100_in;
   logic [8:0]           mod400_ff, mod400_in;
   logic [3:0]           month_ff, month_in;

   logic [5:0]           out_sec_ff, out_min_ff;
   logic [4:0]           out_hour_ff;
   logic [2:0]           out_wday_ff;
   logic [7:0]           out_year_ff;
   logic [3:0]           out_month_ff;
   logic [4:0]           out_day_ff;

   logic [ProdWidth-1:0] prod;
   logic [SecWidth-1:0]  quo_sel;
   logic [RemWidth-1:0]  rem;
   logic                 leap;
   logic [YearLenW-1:0]  year_len;
   logic [MonthLenW-1:0] mon_len;
   logic [DaysWidth:0]   wd_base;

   // Top bits of dividend times reciprocal give the exact quotient over each phase's range.
   assign prod = ProdWidth'(dvd_ff) * ProdWidth'(recip_of(cmd.phase));

   always_comb begin
      unique case (cmd.phase) inside
         PH_SEC, PH_MIN: quo_sel = SecWidth'(prod[ProdWidth-1:QuoLsb60]);
         PH_HOUR:        quo_sel = SecWidth'(prod[ProdWidth-1:QuoLsb24]);
         PH_WDAY:        quo_sel = prod[QuoLsb7+SecWidth-1:QuoLsb7];
         default:        quo_sel = SecWidth'(prod[ProdWidth-1:QuoLsb60]);
      endcase
   end

   // Remainder is below 64, so the low bits of dividend minus quotient times divisor suffice.
   assign rem = dvd_ff[RemWidth-1:0]
                - RemWidth'(quo_ff[RemWidth-1:0] * divisor_of(cmd.phase));

   assign leap     = ((mod4_ff == 2'd0) && (mod100_ff != 7'd0)) || (mod400_ff == 9'd0);
   assign year_len = leap ? LeapYearLen : PlainYearLen;
   assign mon_len  = month_len(month_ff, leap);
   assign wd_base  = {1'b0, quo_ff[DaysWidth-1:0]} + {{(DaysWidth-2){1'b0}}, EpochWdShift};

   always_comb begin
      status            = '0;
      status.year_fits  = (days_ff >= {{(DaysWidth-YearLenW){1'b0}}, year_len})
                          && (year_ff != YearLimit);
      status.month_fits = (month_ff != LastMonth)
                          && (days_ff >= {{(DaysWidth-MonthLenW){1'b0}}, mon_len});
   end

   always_comb begin
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      days_in   = days_ff;
      year_in   = year_ff;
      mod4_in   = mod4_ff;
      mod100_in = mod100_ff;
      mod400_in = mod400_ff;
      month_in  = month_ff;
      if (cmd.load) begin
         dvd_in    = req_seconds_since_epoch;
         year_in   = '0;
         mod4_in   = EpochMod4;
         mod100_in = EpochMod100;
         mod400_in = EpochMod400;
         month_in  = '0;
      end else if (cmd.div_step) begin
         quo_in = quo_sel;
      end else if (cmd.finish) begin
         dvd_in = quo_ff;
         if (cmd.phase == PH_HOUR) begin
            // Quotient is whole days; divide days plus epoch weekday offset next.
            days_in = quo_ff[DaysWidth-1:0];
            dvd_in  = {{(SecWidth-DaysWidth-1){1'b0}}, wd_base};
         end
      end else if (cmd.year_step) begin
         days_in   = days_ff - {{(DaysWidth-YearLenW){1'b0}}, year_len};
         year_in   = year_ff + 8'd1;
         mod4_in   = mod4_ff + 2'd1;
         mod100_in = (mod100_ff == 7'd99) ? 7'd0 : mod100_ff + 7'd1;
         mod400_in = (mod400_ff == 9'd399) ? 9'd0 : mod400_ff + 9'd1;
      end else if (cmd.month_step) begin
         days_in  = days_ff - {{(DaysWidth-MonthLenW){1'b0}}, mon_len};
         month_in = month_ff + 4'd1;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff    <= dvd_in;
      quo_ff    <= quo_in;
      days_ff   <= days_in;
      year_ff   <= year_in;
      mod4_ff   <= mod4_in;
      mod100_ff <= mod100_in;
      mod400_ff <= mod400_in;
      month_ff  <= month_in;
      if (cmd.finish) begin
         unique case (cmd.phase)
            PH_SEC:  sec_ff  <= rem;
            PH_MIN:  min_ff  <= rem;
            PH_HOUR: hour_ff <= rem[4:0];
            PH_WDAY: wday_ff <= rem[2:0] + 3'd1;
            default: sec_ff  <= rem;
         endcase
      end
      if (cmd.emit) begin
         out_sec_ff   <= sec_ff;
         out_min_ff   <= min_ff;
         out_hour_ff  <= hour_ff;
         out_wday_ff  <= wday_ff;
         out_year_ff  <= year_ff;
         out_month_ff <= month_ff + 4'd1;
         out_day_ff   <= days_ff[4:0] + 5'd1;
      end
   end

   assign rsp_second_of_minute = out_sec_ff;
   assign rsp_minute_of_hour   = out_min_ff;
   assign rsp_hour_of_day      = out_hour_ff;
   assign rsp_weekday          = out_wday_ff;
   assign rsp_year_offset      = out_year_ff;
   assign rsp_month_number     = out_month_ff;
   assign rsp_day_of_month     = out_day_ff;

endmodule
`default_nettype wire

### rtl/usc_ctrl.sv
// Controller: sequences divider phases, year walk, month walk and the result beat.
`default_nettype none
module usc_ctrl
   import usc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   input  wire status_type status,
   output cmd_type         cmd
);

   state_type             state_ff, state_in;
   phase_type             phase_ff, phase_in;
   logic                  valid_ff, valid_in;
   logic                  out_free;

   assign out_free  = !valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         phase_ff <= PH_SEC;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      valid_in = valid_ff;
      cmd      = '0;
      cmd.phase = phase_ff;
      if (valid_ff && rsp_ready) begin
         valid_in = 1'b0;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               phase_in = PH_SEC;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            state_in     = ST_FINISH;
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            unique case (phase_ff)
               PH_SEC: begin
                  phase_in = PH_MIN;
                  state_in = ST_DIV;
               end
               PH_MIN: begin
                  phase_in = PH_HOUR;
                  state_in = ST_DIV;
               end
               PH_HOUR: begin
                  phase_in = PH_WDAY;
                  state_in = ST_DIV;
               end
               default: begin
                  state_in = ST_YEAR;
               end
            endcase
         end
         ST_YEAR: begin
            if (status.year_fits) begin
               cmd.year_step = 1'b1;
            end else begin
               state_in = ST_MONTH;
            end
         end
         ST_MONTH: begin
            if (status.month_fits) begin
               cmd.month_step = 1'b1;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hold until the result register is free, then load it.
            if (out_free) begin
               cmd.emit = 1'b1;
               valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/unix_seconds_to_calendar.sv
// Sequence from input beat to result valid: four constant divisions (60, 60, 24, 7), each
// a divide step and a finish step, then a walk over whole years from 1970 and a walk over
// whole months, each ending when the next does not fit, then the result register is loaded.
// Throughput: one item at a time; the next input beat is taken the cycle after the result
// is loaded, and the load waits while an earlier result has not been taken.
// Synchronous reset clears the controller and the result valid flag.
`default_nettype none
module unix_seconds_to_calendar
   import usc_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic [SecWidth-1:0] req_seconds_since_epoch,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [5:0]               rsp_second_of_minute,
   output logic [5:0]               rsp_minute_of_hour,
   output logic [4:0]               rsp_hour_of_day,
   output logic [2:0]               rsp_weekday,
   output logic [7:0]               rsp_year_offset,
   output logic [3:0]               rsp_month_number,
   output logic [4:0]               rsp_day_of_month
);

   cmd_type    cmd;
   status_type status;

   usc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   usc_dpath u_dpath (
      .clock                   (clock),
      .req_seconds_since_epoch (req_seconds_since_epoch),
      .cmd                     (cmd),
      .status                  (status),
      .rsp_second_of_minute    (rsp_second_of_minute),
      .rsp_minute_of_hour      (rsp_minute_of_hour),
      .rsp_hour_of_day         (rsp_hour_of_day),
      .rsp_weekday             (rsp_weekday),
      .rsp_year_offset         (rsp_year_offset),
      .rsp_month_number        (rsp_month_number),
      .rsp_day_of_month        (rsp_day_of_month)
   );

endmodule
`default_nettype wire
